### rtl/tcm_pkg.sv
// Shared types and constants for the triangle centroid Morton code block.
package tcm_pkg;

  localparam int COORD_W  = 32;          // signed Q16.16 coordinate
  localparam int INDEX_W  = 16;          // triangle index
  localparam int CODE_W   = 30;          // Morton code on the port
  localparam int SCALE_W  = 32;          // unsigned Q16.16 scale
  localparam int HALF_W   = 16;          // half of the scale word
  localparam int SUM_W    = 35;          // a + b + c - 3 * min, signed
  localparam int MAG_W    = 34;          // magnitude of a positive sum
  localparam int PROD_W   = MAG_W + HALF_W;      // one partial product
  localparam int TOT_W    = PROD_W + 1;          // partial products added
  localparam int VAL_W    = TOT_W - HALF_W;      // integer part of d * s / 2^32
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [SCALE_W-1:0]        scale_t;
  typedef logic [INDEX_W-1:0]        index_t;
  typedef logic [CODE_W-1:0]         code_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // Stage load strobes handed from the top level to each axis unit
  typedef struct packed {
    logic ld_sum;   // load the offset-sum stage
    logic ld_prod;  // load the partial-product stage
  } pipe_ctrl_t;

endpackage

### rtl/tcm_if.sv
// Valid/ready channel interfaces for triangle words and Morton code words.
interface tcm_in_if import tcm_pkg::*; ();
  logic   valid;
  logic   ready;
  index_t tri_index;
  coord_t a_x;
  coord_t a_y;
  coord_t a_z;
  coord_t b_x;
  coord_t b_y;
  coord_t b_z;
  coord_t c_x;
  coord_t c_y;
  coord_t c_z;

  modport source (
    output valid, tri_index, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, tri_index, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

interface tcm_out_if import tcm_pkg::*; ();
  logic   valid;
  logic   ready;
  index_t out_index;
  code_t  morton_code;

  modport source (
    output valid, out_index, morton_code,
    input  ready
  );
  modport sink (
    input  valid, out_index, morton_code,
    output ready
  );
endinterface

### rtl/tcm_axis.sv
// One axis: offset sum, scale multiply in two halves, floor and clamp.
module tcm_axis import tcm_pkg::*; #(
  parameter int AXIS_BITS = 10
) (
  input  logic                 clk,
  input  pipe_ctrl_t           ctrl,
  input  coord_t               a,
  input  coord_t               b,
  input  coord_t               c,
  input  coord_t               mn,
  input  scale_t               scale,
  output logic [AXIS_BITS-1:0] q
);

  logic signed [SUM_W-1:0] sum_nxt;
  logic                    pos_r, pos_nxt;
  logic [MAG_W-1:0]        mag_r;
  logic                    pos_p_r;
  logic [PROD_W-1:0]       hi_r, hi_nxt;
  logic [PROD_W-1:0]       lo_r, lo_nxt;
  logic [TOT_W-1:0]        tot;
  logic [VAL_W-1:0]        val;
  logic                    sat;

  // Three vertices less three times the minimum: exact in SUM_W bits
  always_comb begin
    sum_nxt = SUM_W'(a) + SUM_W'(b) + SUM_W'(c)
            - (SUM_W'(mn) <<< 1) - SUM_W'(mn);
    pos_nxt = !sum_nxt[SUM_W-1] && (|sum_nxt);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_sum) begin
      pos_r <= pos_nxt;
      mag_r <= sum_nxt[MAG_W-1:0];
    end
  end

  // Split the scale into halves so each product stays narrow
  assign hi_nxt = PROD_W'(mag_r) * PROD_W'(scale[SCALE_W-1:HALF_W]);
  assign lo_nxt = PROD_W'(mag_r) * PROD_W'(scale[HALF_W-1:0]);

  always_ff @(posedge clk) begin
    if (ctrl.ld_prod) begin
      pos_p_r <= pos_r;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
    end
  end

  // floor(d * s / 2^32), then saturate; a non-positive sum gives zero
  always_comb begin
    tot = TOT_W'(hi_r) + TOT_W'(lo_r >> HALF_W);
    val = tot[TOT_W-1:HALF_W];
    sat = |val[VAL_W-1:AXIS_BITS];
    if (!pos_p_r) begin
      q = '0;
    end else if (sat) begin
      q = '1;
    end else begin
      q = val[AXIS_BITS-1:0];
    end
  end

endmodule

### rtl/tcm_interleave.sv
// Bit interleave of three axis values into a Morton code, x highest.
module tcm_interleave import tcm_pkg::*; #(
  parameter int AXIS_BITS = 10
) (
  input  logic [AXIS_BITS-1:0] qx,
  input  logic [AXIS_BITS-1:0] qy,
  input  logic [AXIS_BITS-1:0] qz,
  output code_t                code
);

  localparam int ILV_W = (3 * AXIS_BITS > CODE_W) ? 3 * AXIS_BITS : CODE_W;

  logic [ILV_W-1:0] wide;

  always_comb begin
    wide = '0;
    for (int i = 0; i < AXIS_BITS; i++) begin
      wide[3*i+2] = qx[i];
      wide[3*i+1] = qy[i];
      wide[3*i]   = qz[i];
    end
    // drop what does not fit on the port
    code = wide[CODE_W-1:0];
  end

endmodule

### rtl/triangle_centroid_morton_code.sv
// Top level: triangle centroid to 30-bit Morton code, four-stage pipeline.
//
// Usage. Triangle words arrive on in_ch (valid/ready): a 16-bit index and
// three vertices in signed Q16.16. Code words leave on out_ch (valid/ready):
// the index unchanged and a 30-bit Morton code, x in the top bit of each
// triple. The cfg_ port writes the scene minimum and the per-axis scale
// (cfg_idx 0..5); write it only while the pipeline is empty.
// A word passes through the input register, sum register, product register
// and output register before it is presented on out_ch.
// Throughput: one word per cycle unless out_ch stalls; the partial-product
// multipliers set the clock, one 34 x 16 product per half-scale per axis.
// Each stage holds its word only while the stage after it is full and
// stalled, so bubbles close up and in_ch.ready drops only once all four
// stages are full behind a stalled receiver.
// Reset (rst_n low, synchronous) empties the pipeline and clears the six
// registers; a zero scale gives a zero axis value.
module triangle_centroid_morton_code import tcm_pkg::*; #(
  parameter int AXIS_BITS = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  tcm_in_if.sink          in_ch,
  tcm_out_if.source       out_ch,
  input  logic            cfg_we,
  input  cfg_idx_t        cfg_idx,
  input  logic [COORD_W-1:0] cfg_wdata
);

  // Configuration registers
  coord_t min_x_r, min_y_r, min_z_r;
  scale_t scale_x_r, scale_y_r, scale_z_r;

  // Stage valids
  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy0, rdy1, rdy2, rdy3;
  logic ld0, ld1, ld2, ld3;

  // Input register
  index_t idx0_r;
  coord_t ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;

  // Index carried alongside the axis stages
  index_t idx1_r, idx2_r;

  // Output register
  index_t idx3_r;
  code_t  code_r;
  code_t  code_nxt;

  pipe_ctrl_t           ctrl;
  logic [AXIS_BITS-1:0] qx, qy, qz;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r   <= '0;
      min_y_r   <= '0;
      min_z_r   <= '0;
      scale_x_r <= '0;
      scale_y_r <= '0;
      scale_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MIN_X:   min_x_r   <= coord_t'(cfg_wdata);
        REG_MIN_Y:   min_y_r   <= coord_t'(cfg_wdata);
        REG_MIN_Z:   min_z_r   <= coord_t'(cfg_wdata);
        REG_SCALE_X: scale_x_r <= cfg_wdata;
        REG_SCALE_Y: scale_y_r <= cfg_wdata;
        REG_SCALE_Z: scale_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Ready chain: a stage may load when it is empty or its word moves on
  assign rdy3 = !v3_r || out_ch.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  assign ld0 = in_ch.valid && rdy0;
  assign ld1 = v0_r && rdy1;
  assign ld2 = v1_r && rdy2;
  assign ld3 = v2_r && rdy3;

  assign in_ch.ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) begin
        v0_r <= in_ch.valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Capture the triangle word
  always_ff @(posedge clk) begin
    if (ld0) begin
      idx0_r <= in_ch.tri_index;
      ax_r   <= in_ch.a_x;
      ay_r   <= in_ch.a_y;
      az_r   <= in_ch.a_z;
      bx_r   <= in_ch.b_x;
      by_r   <= in_ch.b_y;
      bz_r   <= in_ch.b_z;
      cx_r   <= in_ch.c_x;
      cy_r   <= in_ch.c_y;
      cz_r   <= in_ch.c_z;
    end
  end

  // Carry the index down the pipe
  always_ff @(posedge clk) begin
    if (ld1) begin
      idx1_r <= idx0_r;
    end
    if (ld2) begin
      idx2_r <= idx1_r;
    end
  end

  assign ctrl.ld_sum  = ld1;
  assign ctrl.ld_prod = ld2;

  tcm_axis #(.AXIS_BITS(AXIS_BITS)) u_axis_x (
    .clk   (clk),
    .ctrl  (ctrl),
    .a     (ax_r),
    .b     (bx_r),
    .c     (cx_r),
    .mn    (min_x_r),
    .scale (scale_x_r),
    .q     (qx)
  );

  tcm_axis #(.AXIS_BITS(AXIS_BITS)) u_axis_y (
    .clk   (clk),
    .ctrl  (ctrl),
    .a     (ay_r),
    .b     (by_r),
    .c     (cy_r),
    .mn    (min_y_r),
    .scale (scale_y_r),
    .q     (qy)
  );

  tcm_axis #(.AXIS_BITS(AXIS_BITS)) u_axis_z (
    .clk   (clk),
    .ctrl  (ctrl),
    .a     (az_r),
    .b     (bz_r),
    .c     (cz_r),
    .mn    (min_z_r),
    .scale (scale_z_r),
    .q     (qz)
  );

  tcm_interleave #(.AXIS_BITS(AXIS_BITS)) u_ilv (
    .qx   (qx),
    .qy   (qy),
    .qz   (qz),
    .code (code_nxt)
  );

  // Output register: holds the code word while the receiver stalls
  always_ff @(posedge clk) begin
    if (ld3) begin
      idx3_r <= idx2_r;
      code_r <= code_nxt;
    end
  end

  assign out_ch.valid       = v3_r;
  assign out_ch.out_index   = idx3_r;
  assign out_ch.morton_code = code_r;

  // Input back-pressure only once every stage is occupied
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v0_r && v1_r && v2_r && v3_r))
    else $error("input stalled while a stage is empty");

  // A full product stage behind a stalled output keeps its word
  a_hold_prod: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && v3_r && !out_ch.ready) |=> (v2_r && $stable(idx2_r)))
    else $error("product stage lost its word under a stall");

  // A word leaving the input register lands in the sum stage
  a_move_sum: assert property (@(posedge clk) disable iff (!rst_n)
    ld1 |=> v1_r)
    else $error("sum stage did not take its word");

endmodule
